// ===== src/bda_pkg.sv =====
// Shared types, constants and helpers for the button debounce and auto-repeat unit.
// No dependencies; every other file in src imports this package.
package bda_pkg;

    // Width of the internal time arithmetic; differences wrap at this width.
    localparam int TIME_WIDTH = 32;
    // Width of the time values in the registers and of the item timestamp.
    localparam int CFG_WIDTH  = 32;
    // Compare width large enough for both operands.
    localparam int CMP_WIDTH  = (TIME_WIDTH > CFG_WIDTH) ? TIME_WIDTH : CFG_WIDTH;

    localparam int NUM_KEYS = 3;
    localparam int KEY_UP   = 0;
    localparam int KEY_DOWN = 1;
    localparam int KEY_SEL  = 2;

    // Register map: register i at byte address 4*i.
    localparam int ADDR_WIDTH = 5;
    localparam int REG_IDX_WIDTH = 3;

    typedef enum logic [REG_IDX_WIDTH-1:0] {
        REG_ENABLE,
        REG_LONG_PRESS_ENABLE,
        REG_DEBOUNCE,
        REG_REPEAT_DELAY,
        REG_REPEAT_RATE,
        REG_LONG_PRESS
    } reg_idx_t;

    typedef enum logic [1:0] {
        OP_SAMPLE,
        OP_CLEAR,
        OP_BLOCK,
        OP_APPLY
    } opcode_t;

    // Reset values of the configuration registers.
    localparam logic [CFG_WIDTH-1:0] RST_DEBOUNCE_US     = CFG_WIDTH'(250000);
    localparam logic [CFG_WIDTH-1:0] RST_REPEAT_DELAY_US = CFG_WIDTH'(500000);
    localparam logic [CFG_WIDTH-1:0] RST_REPEAT_RATE_US  = CFG_WIDTH'(100000);
    localparam logic [CFG_WIDTH-1:0] RST_LONG_PRESS_US   = CFG_WIDTH'(5000000);

    typedef logic [TIME_WIDTH-1:0] time_t;

    typedef struct packed {
        logic                 enable;
        logic                 long_press_enable;
        logic [CFG_WIDTH-1:0] debounce_us;
        logic [CFG_WIDTH-1:0] rpt_delay_us;
        logic [CFG_WIDTH-1:0] rpt_rate_us;
        logic [CFG_WIDTH-1:0] long_press_us;
    } cfg_t;

    // One input item.
    typedef struct packed {
        logic [1:0]           opcode;
        logic [CFG_WIDTH-1:0] now_us;
        logic                 up_level;
        logic                 down_level;
        logic                 sel_level;
    } item_t;

    // One result item.
    typedef struct packed {
        logic up_event;
        logic down_event;
        logic sel_event;
        logic up_held;
        logic down_held;
        logic sel_held;
        logic any_held;
        logic long_press;
        logic blocked;
        logic block_consumed;
    } result_t;

    // Per-item control from the top level to one key lane.
    typedef struct packed {
        logic step;
        logic sample;
        logic clear_pressed;
        logic restart;
        logic lp_allow;
    } lane_ctrl_t;

    // Status from one key lane back to the top level.
    typedef struct packed {
        logic pressed_next;
        logic held_next;
        logic held;
        logic lp_fire;
        logic new_press;
    } lane_stat_t;

    // Unsigned compares of a wrapped time difference against a register value.
    function automatic logic time_gt(time_t a, logic [CFG_WIDTH-1:0] b);
        return CMP_WIDTH'(a) > CMP_WIDTH'(b);
    endfunction

    function automatic logic time_lt(time_t a, logic [CFG_WIDTH-1:0] b);
        return CMP_WIDTH'(a) < CMP_WIDTH'(b);
    endfunction

endpackage

// ===== src/bda_cfg_regs.sv =====
// APB-style configuration registers of the button debounce and auto-repeat unit.
// Depends on bda_pkg for the register map and the cfg_t struct.
module bda_cfg_regs import bda_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [CFG_WIDTH-1:0]  pwdata,
    output logic [CFG_WIDTH-1:0]  prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[ADDR_WIDTH-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    // Register writes in the access cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable            <= 1'b0;
            cfg_reg.long_press_enable <= 1'b1;
            cfg_reg.debounce_us       <= RST_DEBOUNCE_US;
            cfg_reg.rpt_delay_us      <= RST_REPEAT_DELAY_US;
            cfg_reg.rpt_rate_us       <= RST_REPEAT_RATE_US;
            cfg_reg.long_press_us     <= RST_LONG_PRESS_US;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_ENABLE:            cfg_reg.enable            <= pwdata[0];
                REG_LONG_PRESS_ENABLE: cfg_reg.long_press_enable <= pwdata[0];
                REG_DEBOUNCE:          cfg_reg.debounce_us       <= pwdata;
                REG_REPEAT_DELAY:      cfg_reg.rpt_delay_us      <= pwdata;
                REG_REPEAT_RATE:       cfg_reg.rpt_rate_us       <= pwdata;
                REG_LONG_PRESS:        cfg_reg.long_press_us     <= pwdata;
                default:               ;
            endcase
        end
    end

    // Read-back mux.
    always_comb
    begin
        case (reg_idx)
            REG_ENABLE:            prdata = CFG_WIDTH'(cfg_reg.enable);
            REG_LONG_PRESS_ENABLE: prdata = CFG_WIDTH'(cfg_reg.long_press_enable);
            REG_DEBOUNCE:          prdata = cfg_reg.debounce_us;
            REG_REPEAT_DELAY:      prdata = cfg_reg.rpt_delay_us;
            REG_REPEAT_RATE:       prdata = cfg_reg.rpt_rate_us;
            REG_LONG_PRESS:        prdata = cfg_reg.long_press_us;
            default:               prdata = '0;
        endcase
    end

endmodule

// ===== src/bda_key_lane.sv =====
// One key lane: press timestamps, held and pressed flags, debounce and repeat logic.
// Depends on bda_pkg for time_t, cfg_t and the lane control and status structs.
module bda_key_lane import bda_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  lane_ctrl_t ctrl,
    input  cfg_t       cfg,
    input  time_t      now,
    input  logic       level,
    output lane_stat_t stat
);

    time_t last_press_reg, last_press_next;
    time_t hold_start_reg, hold_start_next;
    time_t last_repeat_reg, last_repeat_next;
    logic  held_reg, held_next;
    logic  pressed_reg, pressed_next;
    logic  lp_fire;
    logic  new_press;

    time_t                press_gap;
    time_t                hold_time;
    time_t                repeat_gap;
    logic [CFG_WIDTH-1:0] interval;

    // Wrapped time differences for this key.
    assign press_gap  = now - last_press_reg;
    assign hold_time  = now - hold_start_reg;
    assign repeat_gap = now - last_repeat_reg;
    assign interval   = time_lt(hold_time, cfg.rpt_delay_us) ? cfg.rpt_delay_us
                                                             : cfg.rpt_rate_us;

    // Next state for the current item.
    always_comb
    begin
        last_press_next  = last_press_reg;
        hold_start_next  = hold_start_reg;
        last_repeat_next = last_repeat_reg;
        held_next        = held_reg;
        pressed_next     = pressed_reg;
        lp_fire          = 1'b0;
        new_press        = 1'b0;

        if (ctrl.sample)
        begin
            if (level)
            begin
                if (!held_reg)
                begin
                    // A first press counts only after the debounce gap.
                    if (time_gt(press_gap, cfg.debounce_us))
                    begin
                        new_press        = 1'b1;
                        pressed_next     = 1'b1;
                        held_next        = 1'b1;
                        hold_start_next  = now;
                        last_repeat_next = now;
                        last_press_next  = now;
                    end
                end
                else if (ctrl.lp_allow && time_gt(hold_time, cfg.long_press_us))
                begin
                    // Long press fires once and skips the repeat check this item.
                    lp_fire      = 1'b1;
                    pressed_next = 1'b0;
                end
                else if (time_gt(repeat_gap, interval))
                begin
                    pressed_next     = 1'b1;
                    last_repeat_next = now;
                end
            end
            else
            begin
                pressed_next = 1'b0;
                held_next    = 1'b0;
            end
        end

        if (ctrl.clear_pressed)
        begin
            pressed_next = 1'b0;
        end

        if (ctrl.restart)
        begin
            last_press_next = now;
        end
    end

    // State update on each processed item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_press_reg  <= '0;
            hold_start_reg  <= '0;
            last_repeat_reg <= '0;
            held_reg        <= 1'b0;
            pressed_reg     <= 1'b0;
        end
        else if (ctrl.step)
        begin
            last_press_reg  <= last_press_next;
            hold_start_reg  <= hold_start_next;
            last_repeat_reg <= last_repeat_next;
            held_reg        <= held_next;
            pressed_reg     <= pressed_next;
        end
    end

    always_comb
    begin
        stat.pressed_next = pressed_next;
        stat.held_next    = held_next;
        stat.held         = held_reg;
        stat.lp_fire      = lp_fire;
        stat.new_press    = new_press;
    end

endmodule

// ===== src/button_debounce_autorepeat_unit.sv =====
// Top level of the button debounce and auto-repeat unit: input register, key lanes,
// shared block and long-press state, result register. Depends on bda_pkg,
// bda_cfg_regs and bda_key_lane.
//
//   Channel   Signals                                   Direction
//   -------   ---------------------------------------   ---------
//   item      item_valid, item_ready, item (item_t)     in
//   result    result_valid, result_ready, result         out
//   config    psel, penable, pwrite, paddr, pwdata,     in/out
//             prdata, pready
//
// An item waits in the input register while the lane logic works on it; its result
// is registered in the result register when the item leaves the input register.
// A new item is taken every cycle while the result side does not stall; the lane
// state updates as an item moves from the input register into the result register.
// Reset (rst_n, asynchronous, active low) clears all timestamps and flags and
// loads the register defaults.
// When the result is not taken, the result register holds and the input
// register fills; item_ready drops only when both are full.
module button_debounce_autorepeat_unit import bda_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  item_t                 item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [CFG_WIDTH-1:0]  pwdata,
    output logic [CFG_WIDTH-1:0]  prdata,
    output logic                  pready
);

    cfg_t       cfg;
    item_t      in_reg;
    logic       in_valid_reg;
    result_t    out_reg, out_next;
    logic       out_valid_reg;
    logic       step;
    logic       long_fired_reg, long_fired_next;
    logic       block_reg, block_next;
    time_t      now;
    logic       is_sample, is_clear, is_block, is_apply;
    logic       all_up;
    logic       consumed;
    logic       levels [NUM_KEYS];
    lane_ctrl_t lane_ctrl [NUM_KEYS];
    lane_stat_t lane_stat [NUM_KEYS];

    bda_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Handshake: process the held item when the result register is free.
    assign step         = in_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready   = !in_valid_reg || step;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            in_reg <= item;
        end
    end

    // Opcode decode and shared conditions.
    assign now       = TIME_WIDTH'(in_reg.now_us);
    assign is_sample = (in_reg.opcode == OP_SAMPLE);
    assign is_clear  = (in_reg.opcode == OP_CLEAR);
    assign is_block  = (in_reg.opcode == OP_BLOCK);
    assign is_apply  = (in_reg.opcode == OP_APPLY);
    assign all_up    = !(lane_stat[KEY_UP].held || lane_stat[KEY_DOWN].held
                         || lane_stat[KEY_SEL].held);
    assign consumed  = is_apply && block_reg;

    assign levels[KEY_UP]   = in_reg.up_level;
    assign levels[KEY_DOWN] = in_reg.down_level;
    assign levels[KEY_SEL]  = in_reg.sel_level;

    // One lane per key; only the select lane may fire a long press.
    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_lane
        always_comb
        begin
            lane_ctrl[k].step          = step;
            lane_ctrl[k].sample        = is_sample && cfg.enable;
            lane_ctrl[k].clear_pressed = is_clear || is_block || consumed;
            lane_ctrl[k].restart       = consumed && all_up;
            lane_ctrl[k].lp_allow      = (k == KEY_SEL) && cfg.long_press_enable
                                         && !long_fired_reg;
        end

        bda_key_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (lane_ctrl[k]),
            .cfg   (cfg),
            .now   (now),
            .level (levels[k]),
            .stat  (lane_stat[k])
        );
    end

    // Long-press latch and block-until-release state.
    always_comb
    begin
        long_fired_next = long_fired_reg;
        if (lane_stat[KEY_SEL].new_press)
        begin
            long_fired_next = 1'b0;
        end
        else if (lane_stat[KEY_SEL].lp_fire)
        begin
            long_fired_next = 1'b1;
        end

        block_next = block_reg;
        if (is_block)
        begin
            block_next = 1'b1;
        end
        else if (consumed && all_up)
        begin
            block_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_fired_reg <= 1'b0;
            block_reg      <= 1'b0;
        end
        else if (step)
        begin
            long_fired_reg <= long_fired_next;
            block_reg      <= block_next;
        end
    end

    // Result item from the state after this item.
    always_comb
    begin
        out_next.up_event       = lane_stat[KEY_UP].pressed_next;
        out_next.down_event     = lane_stat[KEY_DOWN].pressed_next;
        out_next.sel_event      = lane_stat[KEY_SEL].pressed_next;
        out_next.up_held        = lane_stat[KEY_UP].held_next;
        out_next.down_held      = lane_stat[KEY_DOWN].held_next;
        out_next.sel_held       = lane_stat[KEY_SEL].held_next;
        out_next.any_held       = lane_stat[KEY_UP].held_next || lane_stat[KEY_DOWN].held_next
                                  || lane_stat[KEY_SEL].held_next;
        out_next.long_press     = lane_stat[KEY_SEL].lp_fire;
        out_next.blocked        = block_next;
        out_next.block_consumed = consumed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= out_next;
        end
    end

    // A key can only be flagged pressed while it is accepted as held.
    a_pressed_needs_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((!out_reg.up_event || out_reg.up_held)
                           && (!out_reg.down_event || out_reg.down_held)
                           && (!out_reg.sel_event || out_reg.sel_held)))
        else $error("pressed flag set on a key that is not held");

    // A long press fires only on a held select key and drops its pressed flag.
    a_long_press_sel: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.long_press) |-> (out_reg.sel_held && !out_reg.sel_event))
        else $error("long press on a select key that is not held");

    // An applied block always leaves every pressed flag clear.
    a_consumed_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.block_consumed)
            |-> !(out_reg.up_event || out_reg.down_event || out_reg.sel_event))
        else $error("pressed flag survived an applied block");

    // A stalled result keeps the item in the input register until it moves on.
    a_in_reg_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !step) |=> (in_valid_reg && $stable(in_reg)))
        else $error("input item lost during a stall");

endmodule

// ===== bench/button_debounce_autorepeat_unit_tb.sv =====
// Self-checking bench for the button debounce and auto-repeat unit.
// Depends on bda_pkg and button_debounce_autorepeat_unit from src, which needs bda_cfg_regs and bda_key_lane.
`timescale 1ns / 100ps

module button_debounce_autorepeat_unit_tb;
    import bda_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    // Clock, reset and the ports of the unit.
    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  item_valid   = 1'b0;
    logic                  item_ready;
    item_t                 item         = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    result_t               result;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [ADDR_WIDTH-1:0] paddr        = '0;
    logic [CFG_WIDTH-1:0]  pwdata       = '0;
    logic [CFG_WIDTH-1:0]  prdata;
    logic                  pready;

    // Register copies kept by the bench, at their reset values.
    bit          cfg_en       = 1'b0;
    bit          cfg_lp_en    = 1'b1;
    logic [31:0] cfg_debounce = RST_DEBOUNCE_US;
    logic [31:0] cfg_delay    = RST_REPEAT_DELAY_US;
    logic [31:0] cfg_rate     = RST_REPEAT_RATE_US;
    logic [31:0] cfg_long     = RST_LONG_PRESS_US;

    // Key state as the bench tracks it.
    logic [31:0] press_at  [NUM_KEYS];
    logic [31:0] hold_from [NUM_KEYS];
    logic [31:0] repeat_at [NUM_KEYS];
    logic [2:0]  held_q    = '0;
    logic [2:0]  pressed_q = '0;
    bit          lp_done   = 1'b0;
    bit          blk       = 1'b0;

    // Flags expected from the unit, oldest first.
    result_t     flags_due[$];

    // Stimulus state shared by the traffic tasks.
    logic [31:0] cur_us = '0;
    logic [2:0]  levels = '0;
    bit          steady = 1'b0;

    // Run statistics.
    int          n_items     = 0;
    int          n_results   = 0;
    int          n_long      = 0;
    int          n_consumed  = 0;
    int          n_settings  = 0;
    int          mismatches  = 0;
    int          quiet_cycles = 0;
    int          stall_left  = 0;

    button_debounce_autorepeat_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            press_at[k]  = '0;
            hold_from[k] = '0;
            repeat_at[k] = '0;
        end
    end

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic item_t make_item(opcode_t op, logic [31:0] t_us, logic up, logic dn,
                                        logic sel);
        item_t it;
        it.opcode     = op;
        it.now_us     = t_us;
        it.up_level   = up;
        it.down_level = dn;
        it.sel_level  = sel;
        return it;
    endfunction

    // Applies one item to the tracked key state and returns the flags it must produce.
    function automatic result_t advance_keys(item_t it);
        result_t     r;
        logic [2:0]  lvl;
        logic [31:0] held_for;
        logic [31:0] since;
        logic [31:0] interval;
        bit          lp_pulse;
        bit          consumed;
        int          k;
        lvl      = {it.sel_level, it.down_level, it.up_level};
        lp_pulse = 1'b0;
        consumed = 1'b0;
        case (opcode_t'(it.opcode))
            OP_SAMPLE:
            begin
                if (cfg_en)
                begin
                    for (k = 0; k < NUM_KEYS; k++)
                    begin
                        if (!lvl[k])
                        begin
                            pressed_q[k] = 1'b0;
                            held_q[k]    = 1'b0;
                        end
                        else if (!held_q[k])
                        begin
                            // A new press counts only once the debounce time has passed.
                            since = it.now_us - press_at[k];
                            if (since > cfg_debounce)
                            begin
                                pressed_q[k] = 1'b1;
                                held_q[k]    = 1'b1;
                                hold_from[k] = it.now_us;
                                repeat_at[k] = it.now_us;
                                press_at[k]  = it.now_us;
                                if (k == KEY_SEL)
                                    lp_done = 1'b0;
                            end
                        end
                        else
                        begin
                            held_for = it.now_us - hold_from[k];
                            if (k == KEY_SEL && cfg_lp_en && held_for > cfg_long && !lp_done)
                            begin
                                // Long press fires once and takes the place of a repeat.
                                lp_done      = 1'b1;
                                pressed_q[k] = 1'b0;
                                lp_pulse     = 1'b1;
                            end
                            else
                            begin
                                interval = (held_for < cfg_delay) ? cfg_delay : cfg_rate;
                                since    = it.now_us - repeat_at[k];
                                if (since > interval)
                                begin
                                    pressed_q[k] = 1'b1;
                                    repeat_at[k] = it.now_us;
                                end
                            end
                        end
                    end
                end
            end
            OP_CLEAR:
                pressed_q = '0;
            OP_BLOCK:
            begin
                blk       = 1'b1;
                pressed_q = '0;
            end
            default:
            begin
                // Apply: only acts when a block is armed; lifts it once every key is up.
                if (blk)
                begin
                    consumed  = 1'b1;
                    pressed_q = '0;
                    if (held_q == '0)
                    begin
                        for (k = 0; k < NUM_KEYS; k++)
                            press_at[k] = it.now_us;
                        blk = 1'b0;
                    end
                end
            end
        endcase
        r.up_event       = pressed_q[KEY_UP];
        r.down_event     = pressed_q[KEY_DOWN];
        r.sel_event      = pressed_q[KEY_SEL];
        r.up_held        = held_q[KEY_UP];
        r.down_held      = held_q[KEY_DOWN];
        r.sel_held       = held_q[KEY_SEL];
        r.any_held       = |held_q;
        r.long_press     = lp_pulse;
        r.blocked        = blk;
        r.block_consumed = consumed;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("MISMATCH %s at %0t: expected %0h, got %0h", what, $realtime, want, got);
    endtask

    // Hands one item to the unit and records the flags it must produce.
    task automatic send_item(input item_t it);
        int gap;
        gap = steady ? 0 : idle_gap();
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (!item_ready);
        flags_due.push_back(advance_keys(it));
        n_items++;
    endtask

    // Stops sending and waits until every expected result has come back.
    task automatic wait_drained();
        item_valid <= 1'b0;
        while (flags_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes one register, then reads it back.
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        logic [31:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_ENABLE:            cfg_en       = val[0];
            REG_LONG_PRESS_ENABLE: cfg_lp_en    = val[0];
            REG_DEBOUNCE:          cfg_debounce = val;
            REG_REPEAT_DELAY:      cfg_delay    = val;
            REG_REPEAT_RATE:       cfg_rate     = val;
            default:               cfg_long     = val;
        endcase
        if (idx == REG_ENABLE || idx == REG_LONG_PRESS_ENABLE)
            want = {31'b0, val[0]};
        else
            want = val;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== want)
            note_mismatch({"readback of ", idx.name()}, want, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input bit en, input bit lp_en, input logic [31:0] deb,
                              input logic [31:0] dly, input logic [31:0] rate,
                              input logic [31:0] lp_us);
        wait_drained();
        write_reg(REG_ENABLE, {31'b0, en});
        write_reg(REG_LONG_PRESS_ENABLE, {31'b0, lp_en});
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_REPEAT_DELAY, dly);
        write_reg(REG_REPEAT_RATE, rate);
        write_reg(REG_LONG_PRESS, lp_us);
        n_settings++;
    endtask

    // Result side: random back-pressure, switched off during steady stretches.
    always @(posedge clk)
    begin
        if (steady)
            result_ready <= 1'b1;
        else if (stall_left != 0)
        begin
            result_ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else if ($urandom_range(0, 99) < 15)
        begin
            result_ready <= 1'b0;
            stall_left   <= idle_gap();
        end
        else
            result_ready <= 1'b1;
    end

    // Compares each accepted result with the oldest expectation, field by field.
    always @(posedge clk)
    begin : check_flags
        result_t want;
        string   names[10];
        names = '{"up_event", "down_event", "sel_event", "up_held", "down_held",
                  "sel_held", "any_held", "long_press", "blocked", "block_consumed"};
        if (rst_n && result_valid && result_ready)
        begin
            n_results++;
            if (result.long_press === 1'b1)
                n_long++;
            if (result.block_consumed === 1'b1)
                n_consumed++;
            if (flags_due.size() == 0)
                note_mismatch("unexpected result", 32'h0, 32'(result));
            else
            begin
                want = flags_due.pop_front();
                for (int k = 0; k < 10; k++)
                    if (want[9-k] !== result[9-k])
                        note_mismatch(names[k], 32'(want[9-k]), 32'(result[9-k]));
            end
        end
    end

    // Ends the run when nothing has moved for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready) || psel)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired after %0d idle cycles", quiet_cycles);
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // With sampling off after reset, samples change nothing; the other opcodes still act.
    task automatic test_disabled_sampling();
        send_item(make_item(OP_SAMPLE, 32'd300000, 1'b1, 1'b1, 1'b1));
        send_item(make_item(OP_BLOCK, 32'd300001, 1'b1, 1'b1, 1'b1));
        send_item(make_item(OP_APPLY, 32'd300002, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_CLEAR, 32'd300003, 1'b1, 1'b0, 1'b1));
    endtask

    // Hand-built sequence: debounce, repeat delay and rate, long press, block and apply, wrap.
    task automatic test_directed_sequences();
        set_config(1'b1, 1'b1, 32'd10, 32'd50, 32'd20, 32'd200);
        send_item(make_item(OP_SAMPLE, 32'd5,   1'b1, 1'b0, 1'b0));
        send_item(make_item(OP_SAMPLE, 32'd20,  1'b1, 1'b0, 1'b0));
        send_item(make_item(OP_CLEAR,  32'd21,  1'b1, 1'b0, 1'b0));
        send_item(make_item(OP_SAMPLE, 32'd60,  1'b1, 1'b0, 1'b0));
        send_item(make_item(OP_SAMPLE, 32'd71,  1'b1, 1'b0, 1'b0));
        send_item(make_item(OP_SAMPLE, 32'd95,  1'b1, 1'b1, 1'b0));
        send_item(make_item(OP_SAMPLE, 32'd96,  1'b0, 1'b1, 1'b0));
        send_item(make_item(OP_SAMPLE, 32'd200, 1'b0, 1'b0, 1'b1));
        send_item(make_item(OP_SAMPLE, 32'd300, 1'b0, 1'b0, 1'b1));
        send_item(make_item(OP_SAMPLE, 32'd401, 1'b0, 1'b0, 1'b1));
        send_item(make_item(OP_SAMPLE, 32'd402, 1'b0, 1'b0, 1'b1));
        send_item(make_item(OP_BLOCK,  32'd403, 1'b0, 1'b0, 1'b1));
        send_item(make_item(OP_APPLY,  32'd404, 1'b0, 1'b0, 1'b1));
        send_item(make_item(OP_SAMPLE, 32'd405, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_APPLY,  32'd406, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_APPLY,  32'd407, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_SAMPLE, 32'd410, 1'b1, 1'b0, 1'b0));
        send_item(make_item(OP_SAMPLE, 32'hFFFF_FFF0, 1'b1, 1'b1, 1'b1));
        send_item(make_item(OP_SAMPLE, 32'h0000_0005, 1'b1, 1'b1, 1'b1));
        send_item(make_item(OP_SAMPLE, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_SAMPLE, 32'h0000_0000, 1'b1, 1'b1, 1'b1));
    endtask

    // Mostly time-ordered samples with keys held for a while, plus noise items.
    task automatic random_traffic(input int count, input int unsigned step_max,
                                  input logic [31:0] long_jump);
        int          r;
        int          op_pick;
        opcode_t     op;
        logic [31:0] step;
        for (int n = 0; n < count; n++)
        begin
            if (n % 50 == 0)
                steady = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 8)
                send_item(make_item(opcode_t'($urandom_range(0, 3)), $urandom,
                                    1'($urandom), 1'($urandom), 1'($urandom)));
            else
            begin
                if (r < 12)
                    step = long_jump + $urandom_range(1, step_max);
                else
                    step = $urandom_range(0, step_max);
                cur_us = cur_us + step;
                for (int k = 0; k < NUM_KEYS; k++)
                    if ($urandom_range(0, 99) < 12)
                        levels[k] = ~levels[k];
                op_pick = $urandom_range(0, 99);
                if (op_pick < 88)
                    op = OP_SAMPLE;
                else if (op_pick < 92)
                    op = OP_CLEAR;
                else if (op_pick < 96)
                    op = OP_BLOCK;
                else
                    op = OP_APPLY;
                send_item(make_item(op, cur_us, levels[KEY_UP], levels[KEY_DOWN],
                                    levels[KEY_SEL]));
            end
        end
        steady = 1'b0;
    endtask

    // Random traffic under a series of register settings, the extremes among them.
    task automatic test_random_traffic();
        cur_us = $urandom;
        set_config(1'b1, 1'b1, RST_DEBOUNCE_US, RST_REPEAT_DELAY_US, RST_REPEAT_RATE_US,
                   RST_LONG_PRESS_US);
        random_traffic(300, 150000, RST_LONG_PRESS_US);
        set_config(1'b1, 1'b1, $urandom_range(0, 20), $urandom_range(0, 60),
                   $urandom_range(0, 30), $urandom_range(50, 300));
        random_traffic(350, 40, cfg_long);
        set_config(1'b1, 1'b1, 32'h0, 32'h0, 32'h0, 32'h0);
        random_traffic(200, 3, 32'h0);
        set_config(1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_traffic(150, 32'hFFFF_FFFF, 32'h0);
        set_config(1'b1, 1'b0, $urandom_range(0, 20), $urandom_range(0, 60),
                   $urandom_range(0, 30), $urandom_range(0, 100));
        random_traffic(300, 40, cfg_long);
        set_config(1'b1, 1'b1, $urandom, $urandom, $urandom, $urandom);
        random_traffic(300, 32'h8000_0000, cfg_long);
        set_config(1'b0, 1'b1, 32'd5, 32'd10, 32'd5, 32'd40);
        random_traffic(50, 20, cfg_long);
        set_config(1'b1, 1'b1, 32'd5, 32'd10, 32'd5, 32'd40);
        random_traffic(250, 20, cfg_long);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_disabled_sampling();
        test_directed_sequences();
        test_random_traffic();

        wait_drained();
        repeat (10) @(posedge clk);
        if (flags_due.size() != 0)
            note_mismatch("results never delivered", 32'h0, 32'(flags_due.size()));
        $display("Checked %0d items and %0d results under %0d register settings.",
                 n_items, n_results, n_settings);
        $display("Long presses seen: %0d, blocks consumed: %0d, mismatches: %0d.",
                 n_long, n_consumed, mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/bda_pkg.sv
src/bda_cfg_regs.sv
src/bda_key_lane.sv
src/button_debounce_autorepeat_unit.sv
bench/button_debounce_autorepeat_unit_tb.sv
